// ===== rtl/wheel_odometer_speedometer_unit_macros.svh =====
// Assertion macros for the top-level RTL file of the wheel odometer and speedometer unit.
`ifndef WHEEL_ODOMETER_SPEEDOMETER_UNIT_MACROS_SVH
`define WHEEL_ODOMETER_SPEEDOMETER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on the clock, skipped while reset is asserted.
`define WOS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("wos assertion failed");
// Property checked on the clock, reset included.
`define WOS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("wos assertion failed");
`else
`define WOS_ASSERT(label, clk, rst_n, prop)
`define WOS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/wos_pkg.sv =====
// Shared constants and types of the wheel odometer and speedometer unit.
`timescale 1ns / 1ps
package wos_pkg;
	localparam int DIST_W   = 20;
	localparam int SPEED_W  = 16;
	localparam int PPU_W    = 10;
	localparam int GAP_W    = 8;
	localparam int TIMER_W  = 16;
	localparam int OVF_W    = 8;
	localparam int PERIOD_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PPU_W-1:0]   PPU_RESET   = 10'd740;
	localparam logic [DIST_W-1:0]  LIMIT_RESET = 20'd600000;
	localparam logic [SPEED_W-1:0] SPEED_K_RESET = 16'd23414;
	localparam logic [GAP_W-1:0]   GAP_RESET   = 8'd10;
	localparam logic [DIST_W-1:0]  START_DIST_RESET = 20'd0;
	localparam logic [TIMER_W-1:0] TIMER_RESET = 16'hFDA8;
	localparam logic [GAP_W-1:0]   PHASE_HOLD  = 8'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_UNIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CONSTANT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_GAP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DISTANCE  = 3'd4;

	// One classified tick as handed from the front to the back.
	typedef struct packed {
		logic [DIST_W-1:0]   distance;
		logic                stopped;
		logic                updated;
		logic                recompute;
		logic [PERIOD_W-1:0] period;
	} entry_t;
endpackage

// ===== rtl/wos_front.sv =====
// Front end: tick timer, pulse counting, distance and period capture per accepted tick.
`timescale 1ns / 1ps
module wos_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              pulse_edge,
	input  logic                              cfg_write,
	input  logic [wos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wos_pkg::CFG_DATA_W-1:0]    cfg_data,
	output wos_pkg::entry_t                   entry
);
	logic [wos_pkg::PPU_W-1:0]   ppu_q;
	logic [wos_pkg::DIST_W-1:0]  limit_q;
	logic [wos_pkg::GAP_W-1:0]   gap_q;
	logic                        dirty_q;

	logic [wos_pkg::TIMER_W-1:0] timer_q;
	logic [wos_pkg::OVF_W-1:0]   ovf_q;
	logic [wos_pkg::PPU_W-1:0]   upc_q;
	logic [wos_pkg::GAP_W-1:0]   phase_q;
	logic [wos_pkg::DIST_W-1:0]  dist_q;
	logic [wos_pkg::OVF_W-1:0]   cap_ovf_q;
	logic [7:0]                  cap_hb_q;
	logic                        stopped_q;

	logic                        pulse;
	logic [wos_pkg::PPU_W-1:0]   upc_inc;
	logic [wos_pkg::GAP_W-1:0]   phase_inc;
	logic                        capture;
	logic                        clear;
	logic                        hit;
	logic                        bump;
	logic [wos_pkg::TIMER_W-1:0] timer_base;
	logic [wos_pkg::TIMER_W-1:0] timer_n;
	logic [wos_pkg::OVF_W-1:0]   ovf_base;
	logic [wos_pkg::OVF_W-1:0]   ovf_n;
	logic [wos_pkg::PPU_W-1:0]   upc_n;
	logic [wos_pkg::GAP_W-1:0]   phase_n;
	logic [wos_pkg::DIST_W-1:0]  dist_n;
	logic [wos_pkg::OVF_W-1:0]   cap_ovf_n;
	logic [7:0]                  cap_hb_n;
	logic                        stopped_n;

	always_comb begin
		pulse     = pulse_edge & ~stopped_q;
		upc_inc   = upc_q + 1'b1;
		phase_inc = phase_q + 1'b1;
		capture   = pulse && (phase_inc == '0);
		clear     = pulse && !capture && (phase_inc == gap_q);
		hit       = pulse && (dist_q == limit_q);
		bump      = pulse && !hit && (upc_inc >= ppu_q);

		upc_n     = pulse ? (bump ? '0 : upc_inc) : upc_q;
		phase_n   = pulse ? (clear ? wos_pkg::PHASE_HOLD : phase_inc) : phase_q;
		dist_n    = bump ? dist_q + 1'b1 : dist_q;
		stopped_n = stopped_q | hit;
		cap_ovf_n = capture ? ovf_q : cap_ovf_q;
		cap_hb_n  = capture ? timer_q[wos_pkg::TIMER_W-1 -: 8] : cap_hb_q;

		// Pulse work sees the timer before this tick's increment.
		timer_base = clear ? '0 : timer_q;
		ovf_base   = (capture || clear) ? '0 : ovf_q;
		timer_n    = timer_base + 1'b1;
		ovf_n      = (timer_n == '0) ? ovf_base + 1'b1 : ovf_base;

		entry.distance  = dist_n;
		entry.stopped   = stopped_n;
		entry.updated   = capture;
		entry.recompute = capture | dirty_q;
		entry.period    = {cap_ovf_n, cap_hb_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppu_q     <= wos_pkg::PPU_RESET;
			limit_q   <= wos_pkg::LIMIT_RESET;
			gap_q     <= wos_pkg::GAP_RESET;
			dirty_q   <= 1'b0;
			timer_q   <= wos_pkg::TIMER_RESET;
			ovf_q     <= '0;
			upc_q     <= '0;
			phase_q   <= '0;
			dist_q    <= wos_pkg::START_DIST_RESET;
			cap_ovf_q <= '0;
			cap_hb_q  <= '0;
			stopped_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				wos_pkg::CFG_PULSES_PER_UNIT: ppu_q <= cfg_data[wos_pkg::PPU_W-1:0];
				wos_pkg::CFG_DISTANCE_LIMIT:  limit_q <= cfg_data[wos_pkg::DIST_W-1:0];
				wos_pkg::CFG_SPEED_CONSTANT:  dirty_q <= 1'b1;
				wos_pkg::CFG_CAPTURE_GAP:     gap_q <= cfg_data[wos_pkg::GAP_W-1:0];
				wos_pkg::CFG_START_DISTANCE:  dist_q <= cfg_data[wos_pkg::DIST_W-1:0];
				default: ;
			endcase
		end else if (accept) begin
			dirty_q   <= 1'b0;
			timer_q   <= timer_n;
			ovf_q     <= ovf_n;
			upc_q     <= upc_n;
			phase_q   <= phase_n;
			dist_q    <= dist_n;
			cap_ovf_q <= cap_ovf_n;
			cap_hb_q  <= cap_hb_n;
			stopped_q <= stopped_n;
		end
	end
endmodule

// ===== rtl/wos_fifo.sv =====
// Short queue of classified ticks between the front and the back.
`timescale 1ns / 1ps
module wos_fifo #(
	parameter int Depth = wos_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  wos_pkg::entry_t wr_data,
	input  logic            rd_en,
	output wos_pkg::entry_t rd_data,
	output logic            full,
	output logic            empty
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	wos_pkg::entry_t slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (cnt_q == FullCnt);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== rtl/wos_back.sv =====
// Back end: speed divider and the result register.
`timescale 1ns / 1ps
module wos_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [wos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wos_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              q_empty,
	input  wos_pkg::entry_t                   q_data,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic [wos_pkg::DIST_W-1:0]        distance,
	output logic [wos_pkg::SPEED_W-1:0]       speed,
	output logic                              limit_reached,
	output logic                              speed_updated,
	output logic                              busy
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;
	localparam int   DW = wos_pkg::SPEED_W;
	localparam int   CntW = $clog2(DW);

	logic                         state_q;
	logic [DW-1:0]                speed_k_q;
	logic [DW-1:0]                speed_q;
	logic [wos_pkg::PERIOD_W-1:0] div_q;
	logic [DW-1:0]                rem_q;
	logic [DW-1:0]                quo_q;
	logic [CntW-1:0]              cnt_q;
	logic [wos_pkg::DIST_W-1:0]   hold_dist_q;
	logic                         hold_stop_q;
	logic                         hold_upd_q;

	logic                         out_valid_q;
	logic [wos_pkg::DIST_W-1:0]   out_dist_q;
	logic [DW-1:0]                out_speed_q;
	logic                         out_stop_q;
	logic                         out_upd_q;

	logic                         slot_free;
	logic                         start_div;
	logic [DW:0]                  rem_sh;
	logic                         ge;
	logic [DW:0]                  rem_sub;
	logic [DW-1:0]                rem_n;
	logic [DW-1:0]                quo_n;
	logic                         last_step;

	assign slot_free = !out_valid_q || pop;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && slot_free;
	assign start_div = q_pop && q_data.recompute && (q_data.period != '0);
	assign last_step = (state_q == ST_DIV) && (cnt_q == '0);
	assign busy      = (state_q == ST_DIV);

	// Restoring division, one quotient bit a cycle.
	always_comb begin
		rem_sh  = {rem_q, quo_q[DW-1]};
		ge      = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
		rem_n   = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		quo_n   = {quo_q[DW-2:0], ge};
	end

	assign empty         = !out_valid_q;
	assign distance      = out_dist_q;
	assign speed         = out_speed_q;
	assign limit_reached = out_stop_q;
	assign speed_updated = out_upd_q;

	always_ff @(posedge clk) begin
		if (start_div) begin
			div_q       <= q_data.period;
			rem_q       <= '0;
			quo_q       <= speed_k_q;
			hold_dist_q <= q_data.distance;
			hold_stop_q <= q_data.stopped;
			hold_upd_q  <= q_data.updated;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			speed_k_q   <= wos_pkg::SPEED_K_RESET;
			speed_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_dist_q  <= '0;
			out_speed_q <= '0;
			out_stop_q  <= 1'b0;
			out_upd_q   <= 1'b0;
		end else begin
			if (cfg_write && (cfg_index == wos_pkg::CFG_SPEED_CONSTANT)) begin
				speed_k_q <= cfg_data[DW-1:0];
			end
			// Drop the transferred result unless a new one loads in its place.
			if (pop && out_valid_q && !(q_pop && !start_div)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start_div) begin
						state_q <= ST_DIV;
						cnt_q   <= CntW'(DW - 1);
					end else if (q_pop) begin
						// A tick with no recompute keeps the last speed; a zero period gives zero speed without dividing.
						out_valid_q <= 1'b1;
						out_dist_q  <= q_data.distance;
						out_stop_q  <= q_data.stopped;
						out_upd_q   <= q_data.updated;
						if (q_data.recompute) begin
							speed_q     <= '0;
							out_speed_q <= '0;
						end else begin
							out_speed_q <= speed_q;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (last_step) begin
						// Result slot stayed empty since the divide started.
						state_q     <= ST_IDLE;
						speed_q     <= quo_n;
						out_valid_q <= 1'b1;
						out_dist_q  <= hold_dist_q;
						out_speed_q <= quo_n;
						out_stop_q  <= hold_stop_q;
						out_upd_q   <= hold_upd_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/wheel_odometer_speedometer_unit.sv =====
// Top level of the wheel odometer and speedometer unit.
//
// Channel  Direction  Handshake          Payload
// input    in         push / full        pulse_edge
// result   out        empty / pop        distance, speed, limit_reached, speed_updated
// config   in         cfg_valid / ready  cfg_index, cfg_data
//
// A tick is taken by the front and queued; a tick without a speed recompute passes
// through the queue into the result register, at one tick per cycle while the back is idle and results are popped.
// A capture, or the first tick after a speed_constant write, with a nonzero period runs
// through the 16-step serial divider in the back; the queue absorbs the stall until full.
// Reset is asynchronous and clears every counter to its start value at once.
// cfg_ready is always high; writes are meant for an idle block.
`timescale 1ns / 1ps
`include "wheel_odometer_speedometer_unit_macros.svh"
module wheel_odometer_speedometer_unit #(
	parameter int QueueDepth = wos_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              pulse_edge,
	output logic                              empty,
	input  logic                              pop,
	output logic [wos_pkg::DIST_W-1:0]        distance,
	output logic [wos_pkg::SPEED_W-1:0]       speed,
	output logic                              limit_reached,
	output logic                              speed_updated,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wos_pkg::CFG_DATA_W-1:0]    cfg_data
);
	logic            accept;
	logic            cfg_write;
	wos_pkg::entry_t front_entry;
	wos_pkg::entry_t q_data;
	logic            q_empty;
	logic            q_pop;
	logic            back_busy;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;
	assign accept    = push & ~full;

	wos_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.pulse_edge (pulse_edge),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.entry      (front_entry)
	);

	wos_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_entry),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	wos_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_empty       (q_empty),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.distance      (distance),
		.speed         (speed),
		.limit_reached (limit_reached),
		.speed_updated (speed_updated),
		.busy          (back_busy)
	);

	`WOS_ASSERT(a_queue_full_not_empty, clk, arst_n, full |-> !q_empty)
	`WOS_ASSERT(a_div_slot_empty, clk, arst_n, back_busy |-> empty)
	`WOS_ASSERT(a_transfer_queued, clk, arst_n, (push && !full) |=> !q_empty)
endmodule

// ===== tb/sv/wos_odometer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the wheel odometer and speedometer unit: predicts each reading and compares.
module wos_odometer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  logic                           pulse_edge,
	input  logic                           empty,
	input  logic                           pop,
	input  logic [wos_pkg::DIST_W-1:0]     distance,
	input  logic [wos_pkg::SPEED_W-1:0]    speed,
	input  logic                           limit_reached,
	input  logic                           speed_updated,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [wos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wos_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);
	typedef struct packed {
		logic [wos_pkg::DIST_W-1:0]  distance;
		logic [wos_pkg::SPEED_W-1:0] speed;
		logic                        limit_reached;
		logic                        speed_updated;
	} reading_t;

	reading_t expected_readings[$];

	// register copies
	logic [wos_pkg::PPU_W-1:0]   ppu_reg;
	logic [wos_pkg::DIST_W-1:0]  limit_reg;
	logic [wos_pkg::SPEED_W-1:0] k_reg;
	logic [wos_pkg::GAP_W-1:0]   gap_reg;

	// odometer state
	logic [wos_pkg::TIMER_W-1:0] timer_q;
	logic [wos_pkg::OVF_W-1:0]   ovf_q;
	logic [wos_pkg::PPU_W-1:0]   unit_cnt_q;
	logic [wos_pkg::GAP_W-1:0]   phase_q;
	logic [wos_pkg::DIST_W-1:0]  dist_q;
	logic [wos_pkg::OVF_W-1:0]   cap_ovf_q;
	logic [7:0]                  cap_hi_q;
	logic                        stopped_q;

	// One timer tick: the pulse sees the timer from before this tick's increment.
	task automatic advance_tick(input logic pe, output reading_t r);
		logic                         captured;
		logic [wos_pkg::PERIOD_W-1:0] period;
		captured = 1'b0;
		if (pe && !stopped_q) begin
			unit_cnt_q = unit_cnt_q + 1'b1;
			phase_q = phase_q + 1'b1;
			if (phase_q == '0) begin
				cap_ovf_q = ovf_q;
				ovf_q = '0;
				cap_hi_q = timer_q[wos_pkg::TIMER_W-1:8];
				captured = 1'b1;
			end else if (phase_q == gap_reg) begin
				timer_q = '0;
				phase_q = wos_pkg::PHASE_HOLD;
				ovf_q = '0;
			end
			if (dist_q == limit_reg)
				stopped_q = 1'b1;
			else if (unit_cnt_q >= ppu_reg) begin
				unit_cnt_q = '0;
				dist_q = dist_q + 1'b1;
			end
		end
		timer_q = timer_q + 1'b1;
		if (timer_q == '0)
			ovf_q = ovf_q + 1'b1;
		period = {cap_ovf_q, cap_hi_q};
		r.distance = dist_q;
		r.speed = (period == '0) ? '0 : k_reg / period;
		r.limit_reached = stopped_q;
		r.speed_updated = captured;
	endtask

	task automatic check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			ppu_reg = wos_pkg::PPU_RESET;
			limit_reg = wos_pkg::LIMIT_RESET;
			k_reg = wos_pkg::SPEED_K_RESET;
			gap_reg = wos_pkg::GAP_RESET;
			timer_q = wos_pkg::TIMER_RESET;
			ovf_q = '0;
			unit_cnt_q = '0;
			phase_q = '0;
			dist_q = wos_pkg::START_DIST_RESET;
			cap_ovf_q = '0;
			cap_hi_q = '0;
			stopped_q = 1'b0;
			expected_readings.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wos_pkg::CFG_PULSES_PER_UNIT:
						ppu_reg = cfg_data[wos_pkg::PPU_W-1:0];
					wos_pkg::CFG_DISTANCE_LIMIT:
						limit_reg = cfg_data[wos_pkg::DIST_W-1:0];
					wos_pkg::CFG_SPEED_CONSTANT:
						k_reg = cfg_data[wos_pkg::SPEED_W-1:0];
					wos_pkg::CFG_CAPTURE_GAP:
						gap_reg = cfg_data[wos_pkg::GAP_W-1:0];
					wos_pkg::CFG_START_DISTANCE:
						dist_q = cfg_data[wos_pkg::DIST_W-1:0];
					default: ;
				endcase
			end
			// compare before predicting: a reading never leaves in the edge that takes its tick
			if (pop && !empty) begin
				got = {distance, speed, limit_reached, speed_updated};
				if (expected_readings.size() == 0) begin
					mismatches++;
					$display("%0t: reading expected none, got distance %0d speed %0d",
						$time, got.distance, got.speed);
				end else begin
					want = expected_readings.pop_front();
					check_field("distance", 32'(want.distance), 32'(got.distance));
					check_field("speed", 32'(want.speed), 32'(got.speed));
					check_field("limit_reached", 32'(want.limit_reached),
						32'(got.limit_reached));
					check_field("speed_updated", 32'(want.speed_updated),
						32'(got.speed_updated));
				end
			end
			if (push && !full) begin
				advance_tick(pulse_edge, want);
				expected_readings.push_back(want);
			end
			outstanding = expected_readings.size();
		end
	end
endmodule

// ===== tb/sv/wheel_odometer_speedometer_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the wheel odometer and speedometer unit: reset, stimulus and verdict.
module wheel_odometer_speedometer_unit_tb;
	typedef enum int {MIX_HALF, MIX_THIRD, MIX_EIGHTH, MIX_SPACED} pulse_mix_t;
	typedef logic [wos_pkg::CFG_DATA_W-1:0] cfg_word_t;
	typedef logic [wos_pkg::DIST_W-1:0]     dist_word_t;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_AT     = 1000;
	localparam int unsigned HOLD_LEN    = 150;
	localparam int unsigned SETTLE      = 24;
	localparam int unsigned PHASE_SPAN  = 256;
	localparam int unsigned WRAP_TICKS  = 640;
	localparam logic [wos_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
	localparam logic [wos_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam logic [7:0] OPENING_PULSES = 8'b1101_0110;
	localparam logic [7:0] WRAP_PULSES    = 8'b1110_1111;

	logic                           clk;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic                           pulse_edge;
	logic                           empty;
	logic                           pop;
	logic [wos_pkg::DIST_W-1:0]     distance;
	logic [wos_pkg::SPEED_W-1:0]    speed;
	logic                           limit_reached;
	logic                           speed_updated;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [wos_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [wos_pkg::CFG_DATA_W-1:0] cfg_data;

	int          mismatches;
	int          outstanding;
	bit          calm = 1'b0;
	int unsigned pulses_sent = 0;
	int unsigned ticks_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned spaced_wait = 0;
	bit          spaced_long = 1'b0;

	wheel_odometer_speedometer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.pulse_edge    (pulse_edge),
		.empty         (empty),
		.pop           (pop),
		.distance      (distance),
		.speed         (speed),
		.limit_reached (limit_reached),
		.speed_updated (speed_updated),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	wos_odometer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.pulse_edge    (pulse_edge),
		.empty         (empty),
		.pop           (pop),
		.distance      (distance),
		.speed         (speed),
		.limit_reached (limit_reached),
		.speed_updated (speed_updated),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Random bits above the register width, value in the low bits.
	function automatic cfg_word_t with_junk(input int width, input int unsigned value);
		cfg_word_t junk;
		junk = cfg_word_t'($urandom);
		junk = (junk >> width) << width;
		return junk | cfg_word_t'(value);
	endfunction

	task automatic write_reg(input logic [wos_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input cfg_word_t ppu_word, limit_word, k_word,
			gap_word, start_word);
		write_reg(wos_pkg::CFG_PULSES_PER_UNIT, ppu_word);
		write_reg(wos_pkg::CFG_DISTANCE_LIMIT, limit_word);
		write_reg(wos_pkg::CFG_SPEED_CONSTANT, k_word);
		write_reg(wos_pkg::CFG_CAPTURE_GAP, gap_word);
		write_reg(wos_pkg::CFG_START_DISTANCE, start_word);
		cfg_valid <= 1'b0;
	endtask

	// Drop push and wait until every reading has been popped, then let the divider settle.
	task automatic drain();
		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send_tick(input logic pe);
		int unsigned pause;
		if (!calm && $urandom_range(0, 7) == 0) begin
			pause = $urandom_range(1, 6);
			push <= 1'b0;
			repeat (pause) @(negedge clk);
		end
		push <= 1'b1;
		pulse_edge <= pe;
		@(posedge clk);
		while (full) @(posedge clk);
		ticks_sent++;
		if (pe)
			pulses_sent++;
		@(negedge clk);
	endtask

	// Spaced mix alternates a short wait (before the clearing pulse) and a long one
	// (before the capturing pulse), so captured periods can get a nonzero high byte.
	task automatic next_pulse(input pulse_mix_t mix, output logic pe);
		case (mix)
			MIX_HALF:   pe = ($urandom_range(0, 1) == 1);
			MIX_THIRD:  pe = ($urandom_range(0, 2) == 0);
			MIX_EIGHTH: pe = ($urandom_range(0, 7) == 0);
			default: begin
				if (spaced_wait == 0) begin
					pe = 1'b1;
					spaced_long = !spaced_long;
					spaced_wait = spaced_long ? $urandom_range(150, 500) : $urandom_range(0, 2);
				end else begin
					pe = 1'b0;
					spaced_wait--;
				end
			end
		endcase
	endtask

	task automatic run_ticks(input pulse_mix_t mix, input int unsigned count);
		logic pe;
		repeat (count) begin
			next_pulse(mix, pe);
			send_tick(pe);
		end
	endtask

	initial begin
		int unsigned stall_left;
		int unsigned rx_cycles;
		pop = 1'b0;
		stall_left = 0;
		rx_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycles++;
			// one long hold-off so the queue fills and push backs up
			if (rx_cycles == HOLD_AT)
				stall_left = HOLD_LEN;
			else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 6);
			if (stall_left != 0) begin
				pop <= 1'b0;
				stall_left--;
			end else
				pop <= 1'b1;
		end
	end

	initial begin
		dist_word_t start;
		logic       pe;
		arst_n = 1'b0;
		push = 1'b0;
		pulse_edge = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = wos_pkg::CFG_PULSES_PER_UNIT;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, fewer pulses than the capture gap
		for (int i = 0; i < 8; i++)
			send_tick(OPENING_PULSES[i]);
		drain();
		write_reg(CFG_UNUSED_LO, cfg_word_t'($urandom));
		write_reg(CFG_UNUSED_HI, cfg_word_t'($urandom));
		// every pulse counts, no timer clear, distance wraps past all ones
		configure(with_junk(wos_pkg::PPU_W, 0), 20'h12345,
			with_junk(wos_pkg::SPEED_W, 32'hFFFF), with_junk(wos_pkg::GAP_W, 0), 20'hFFFFE);
		for (int i = 0; i < 8; i++)
			send_tick(WRAP_PULSES[i]);

		// No clears: the reset timer wraps once, then the 256th pulse captures one overflow.
		drain();
		configure(with_junk(wos_pkg::PPU_W, $urandom_range(1, 6)), 20'd1,
			with_junk(wos_pkg::SPEED_W, $urandom_range(1, 65535)),
			with_junk(wos_pkg::GAP_W, 0), 20'd2);
		while (pulses_sent < PHASE_SPAN) begin
			if (ticks_sent < WRAP_TICKS)
				pe = ($urandom_range(0, 3) == 0) && (pulses_sent < PHASE_SPAN - 1);
			else
				pe = ($urandom_range(0, 1) == 1);
			send_tick(pe);
		end

		// phase counter sits at zero here, so a gap of one pairs clear and capture
		drain();
		configure(with_junk(wos_pkg::PPU_W, $urandom_range(1, 1023)), 20'hFFFFF,
			with_junk(wos_pkg::SPEED_W, 32'hFFFF), with_junk(wos_pkg::GAP_W, 1), 20'd0);
		spaced_long = 1'b0;
		spaced_wait = $urandom_range(0, 2);
		run_ticks(MIX_SPACED, 500);

		drain();
		configure(with_junk(wos_pkg::PPU_W, 1023), 20'd0, with_junk(wos_pkg::SPEED_W, 1),
			with_junk(wos_pkg::GAP_W, 254), 20'd1);
		run_ticks(MIX_HALF, 90);

		drain();
		configure(with_junk(wos_pkg::PPU_W, 0), 20'hFFFEF,
			with_junk(wos_pkg::SPEED_W, 32'hFFFF), with_junk(wos_pkg::GAP_W, 2), 20'hFFFF0);
		run_ticks(MIX_HALF, 90);

		drain();
		start = dist_word_t'($urandom);
		configure(with_junk(wos_pkg::PPU_W, $urandom_range(1, 20)), start - 1'b1,
			with_junk(wos_pkg::SPEED_W, $urandom_range(1, 65535)),
			with_junk(wos_pkg::GAP_W, 255), start);
		run_ticks(MIX_EIGHTH, 90);

		drain();
		start = dist_word_t'($urandom);
		configure(with_junk(wos_pkg::PPU_W, $urandom_range(0, 1023)), start - 1'b1,
			with_junk(wos_pkg::SPEED_W, $urandom_range(1, 65535)),
			with_junk(wos_pkg::GAP_W, $urandom_range(0, 255)), start);
		run_ticks(MIX_THIRD, 90);

		// Last stretch, no idling: distance runs into the limit and the stop sticks.
		drain();
		calm = 1'b1;
		start = dist_word_t'($urandom);
		configure(with_junk(wos_pkg::PPU_W, 1), start + 20'd6,
			with_junk(wos_pkg::SPEED_W, $urandom_range(1, 65535)),
			with_junk(wos_pkg::GAP_W, $urandom_range(1, 8)), start);
		run_ticks(MIX_HALF, 150);

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wos_pkg.sv
rtl/wos_front.sv
rtl/wos_fifo.sv
rtl/wos_back.sv
rtl/wheel_odometer_speedometer_unit.sv
tb/sv/wos_odometer_checker.sv
tb/sv/wheel_odometer_speedometer_unit_tb.sv
